// File: rtl/mbag_pkg.sv
`default_nettype none

package mbag_pkg;

	// Operation selector carried on the slave-side tuser
	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_QUERY  = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	localparam int unsigned KIND_W  = 2;
	localparam int unsigned ITEM_W  = 32;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned RES_W   = 16;

	// Result word, lowest bit first: succeeded, match_count, present,
	// stored_count, full_flag, empty_flag, then zero fill
	typedef struct packed {
		logic [1:0]         pad;
		logic               empty_flag;
		logic               full_flag;
		logic [COUNT_W-1:0] stored_count;
		logic               present;
		logic [COUNT_W-1:0] match_count;
		logic               succeeded;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/mbag_ram.sv
`default_nettype none

module mbag_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 32,
	parameter int unsigned AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/multiset_bag_store.sv
// Unordered multiset of item words held in a synchronous one-port-read RAM.
// Steps per item: accept, scan and last compare (both skipped on an empty store),
// execute, a move for a remove that hits, result; the scan reads one stored entry per cycle.
// Throughput: one item at a time; a new item is taken only once the result is loaded.
// Reset (arst_n low, asynchronous): store empty, no result pending; entry RAM
// is not cleared, as only entries below the fill count are ever used.
`default_nettype none

module multiset_bag_store import mbag_pkg::*; #(
	parameter int unsigned CAPACITY   = 16,
	parameter int unsigned ITEM_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [ITEM_W-1:0] s_tdata,   // [31:0] item
	input  wire logic [KIND_W-1:0] s_tuser,   // [1:0] kind
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [RES_W-1:0]  m_tdata    // [0] succeeded, [5:1] match_count,
	                                          // [6] present, [11:7] stored_count,
	                                          // [12] full_flag, [13] empty_flag
);

	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_EXEC,
		ST_MOVE,
		ST_RESULT
	} state_t;

	state_t                state_q;
	kind_t                 kind_q;
	logic [ITEM_WIDTH-1:0] word_q;
	logic [CNT_W-1:0]      fill_q;
	logic [IDX_W-1:0]      ptr_q;
	logic [CNT_W-1:0]      matches_q;
	logic                  found_q;
	logic [IDX_W-1:0]      found_idx_q;
	logic                  ok_q;
	logic                  cmp_vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  m_tvalid_q;
	res_t                  res_q;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [ITEM_WIDTH-1:0] ram_wdata;
	logic [IDX_W-1:0]      ram_raddr;
	logic [ITEM_WIDTH-1:0] ram_rdata;

	logic [ITEM_WIDTH+ITEM_W-1:0] item_ext;
	logic [ITEM_WIDTH-1:0]        in_word;
	logic [IDX_W-1:0]             last_idx;
	logic [IDX_W-1:0]             tail_idx;
	logic                         is_full;
	logic [CNT_W+COUNT_W-1:0]     matches_ext;
	logic [CNT_W+COUNT_W-1:0]     fill_ext;
	logic                         in_accept;
	logic                         res_load;

	// item masked to the stored width
	assign item_ext  = {{ITEM_WIDTH{1'b0}}, s_tdata};
	assign in_word   = item_ext[ITEM_WIDTH-1:0];
	assign last_idx  = IDX_W'(fill_q - CNT_W'(1));
	assign tail_idx  = IDX_W'(fill_q);
	assign is_full   = (fill_q == CNT_W'(CAPACITY));
	assign in_accept = s_tvalid && s_tready;
	assign res_load  = (state_q == ST_RESULT) && (!m_tvalid_q || m_tready);

	assign matches_ext = {{COUNT_W{1'b0}}, matches_q};
	assign fill_ext    = {{COUNT_W{1'b0}}, fill_q};

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = res_q;

	// RAM port steering: scan reads, tail read for the swap, add/move writes
	always_comb begin
		ram_raddr = (state_q == ST_EXEC) ? last_idx : ptr_q;
		ram_we    = 1'b0;
		ram_waddr = tail_idx;
		ram_wdata = word_q;
		if (state_q == ST_EXEC && kind_q == KIND_ADD && !is_full) begin
			ram_we = 1'b1;
		end
		if (state_q == ST_MOVE) begin
			ram_we    = 1'b1;
			ram_waddr = found_idx_q;
			ram_wdata = ram_rdata;
		end
	end

	mbag_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (ITEM_WIDTH),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer, compare stage and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_ADD;
			word_q      <= '0;
			fill_q      <= '0;
			ptr_q       <= '0;
			matches_q   <= '0;
			found_q     <= 1'b0;
			found_idx_q <= '0;
			ok_q        <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			idx_s1      <= '0;
			m_tvalid_q  <= 1'b0;
			res_q       <= '0;
		end else begin
			cmp_vld_s1 <= (state_q == ST_SCAN);
			idx_s1     <= ptr_q;

			// compare returning entry; first hit remembered for remove
			if (cmp_vld_s1 && ram_rdata == word_q) begin
				matches_q <= matches_q + CNT_W'(1);
				if (!found_q) begin
					found_q     <= 1'b1;
					found_idx_q <= idx_s1;
				end
			end

			// result valid: set on load, dropped once taken
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						kind_q    <= kind_t'(s_tuser);
						word_q    <= in_word;
						ptr_q     <= '0;
						matches_q <= '0;
						found_q   <= 1'b0;
						ok_q      <= 1'b0;
						state_q   <= (fill_q == '0) ? ST_EXEC : ST_SCAN;
					end
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + IDX_W'(1);
					if (ptr_q == last_idx) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					// last compare lands this cycle
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_RESULT;
					unique case (kind_q)
						KIND_ADD: begin
							if (!is_full) begin
								fill_q <= fill_q + CNT_W'(1);
								ok_q   <= 1'b1;
							end
						end
						KIND_REMOVE: begin
							if (found_q) begin
								ok_q    <= 1'b1;
								state_q <= ST_MOVE;
							end
						end
						KIND_QUERY: begin
							ok_q <= found_q;
						end
						KIND_CLEAR: begin
							fill_q <= '0;
							ok_q   <= 1'b1;
						end
						default: begin
							ok_q <= 1'b0;
						end
					endcase
				end
				ST_MOVE: begin
					// tail entry written over the hit
					fill_q  <= fill_q - CNT_W'(1);
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (res_load) begin
						res_q.pad          <= '0;
						res_q.succeeded    <= ok_q;
						res_q.match_count  <= matches_ext[COUNT_W-1:0];
						res_q.present      <= (matches_q != '0);
						res_q.stored_count <= fill_ext[COUNT_W-1:0];
						res_q.full_flag    <= is_full;
						res_q.empty_flag   <= (fill_q == '0);
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_tready)
		else $error("second item taken while one is in work");

	a_present_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (res_q.present == (res_q.match_count != '0)))
		else $error("present flag disagrees with match count");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(res_q.full_flag && res_q.empty_flag))
		else $error("full and empty both set");

endmodule

`default_nettype wire

// File: dv/tb_multiset_bag_store.sv
`timescale 1ns / 100ps

module tb_multiset_bag_store;
	import mbag_pkg::*;

	localparam int unsigned BAG_DEPTH   = 16;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned DRAIN_WAIT  = 40;

	localparam logic [ITEM_W-1:0] WORD_ZERO = 32'h0000_0000;
	localparam logic [ITEM_W-1:0] WORD_ONES = 32'hFFFF_FFFF;
	localparam logic [ITEM_W-1:0] WORD_ALT  = 32'h5A5A_A5A5;
	localparam logic [ITEM_W-1:0] WORD_EDGE = 32'h8000_0001;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [ITEM_W-1:0] s_tdata  = '0;   // [31:0] item
	logic [KIND_W-1:0] s_tuser  = '0;   // [1:0] kind
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [RES_W-1:0]  m_tdata;         // [0] succeeded, [5:1] match_count, [6] present,
	                                    // [11:7] stored_count, [12] full_flag, [13] empty_flag

	// Shadow copy of the bag
	logic [ITEM_W-1:0] shadow_entries [BAG_DEPTH];
	int unsigned       shadow_fill;

	res_t bag_results_due [$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int          hold_left;
	int unsigned cycle_count;
	int unsigned mismatch_count;
	int unsigned items_sent;
	int unsigned results_checked;
	int unsigned kind_seen [4];
	int unsigned full_seen;
	int unsigned remove_hits;
	int unsigned remove_misses;
	int unsigned rejected_adds;
	logic [ITEM_W-1:0] word_pool [6];

	multiset_bag_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// Run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				bag_results_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result side: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Bag behaviour: one operation on the shadow copy, returns the result it gives
	function automatic res_t predict_bag_op(input kind_t op, input logic [ITEM_W-1:0] word);
		res_t        r;
		int unsigned hits;
		r    = '0;
		hits = 0;
		for (int i = 0; i < shadow_fill; i++)
			if (shadow_entries[i] == word)
				hits++;
		case (op)
			KIND_ADD: begin
				if (shadow_fill < BAG_DEPTH) begin
					shadow_entries[shadow_fill] = word;
					shadow_fill++;
					r.succeeded = 1'b1;
				end else begin
					rejected_adds++;
				end
			end
			KIND_REMOVE: begin
				// lowest matching slot takes the last entry
				for (int i = 0; i < shadow_fill; i++) begin
					if (shadow_entries[i] == word) begin
						shadow_entries[i] = shadow_entries[shadow_fill - 1];
						shadow_fill--;
						r.succeeded = 1'b1;
						break;
					end
				end
				if (r.succeeded)
					remove_hits++;
				else
					remove_misses++;
			end
			KIND_QUERY: r.succeeded = (hits != 0);
			default: begin
				shadow_fill = 0;
				r.succeeded = 1'b1;
			end
		endcase
		r.match_count  = hits[COUNT_W-1:0];
		r.present      = (hits != 0);
		r.stored_count = shadow_fill[COUNT_W-1:0];
		r.full_flag    = (shadow_fill == BAG_DEPTH);
		r.empty_flag   = (shadow_fill == 0);
		if (shadow_fill == BAG_DEPTH)
			full_seen++;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR %0t: %s got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Result checker
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata);
			if (bag_results_due.size() == 0) begin
				report_mismatch("result with none due, stored_count",
					int'(got.stored_count), 0);
			end else begin
				want = bag_results_due.pop_front();
				results_checked++;
				if (got.succeeded !== want.succeeded)
					report_mismatch("succeeded", int'(got.succeeded),
						int'(want.succeeded));
				if (got.match_count !== want.match_count)
					report_mismatch("match_count", int'(got.match_count),
						int'(want.match_count));
				if (got.present !== want.present)
					report_mismatch("present", int'(got.present), int'(want.present));
				if (got.stored_count !== want.stored_count)
					report_mismatch("stored_count", int'(got.stored_count),
						int'(want.stored_count));
				if (got.full_flag !== want.full_flag)
					report_mismatch("full_flag", int'(got.full_flag),
						int'(want.full_flag));
				if (got.empty_flag !== want.empty_flag)
					report_mismatch("empty_flag", int'(got.empty_flag),
						int'(want.empty_flag));
			end
		end
	end

	// Offer one item, wait for it to be taken, then log what it should produce
	task automatic send_item(input kind_t op, input logic [ITEM_W-1:0] word);
		int   gap;
		res_t due;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		due = predict_bag_op(op, word);
		bag_results_due = {bag_results_due, due};
		items_sent++;
		kind_seen[op]++;
	endtask

	task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Small pool of words so that duplicates and hits are common
	task automatic refresh_pool();
		word_pool[0] = WORD_ZERO;
		word_pool[1] = WORD_ONES;
		for (int i = 2; i < 6; i++)
			word_pool[i] = $urandom;
	endtask

	task automatic random_ops(input int n, input int add_w, input int rem_w, input int qry_w);
		int          r;
		kind_t       op;
		logic [ITEM_W-1:0] word;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < add_w)
				op = KIND_ADD;
			else if (r < add_w + rem_w)
				op = KIND_REMOVE;
			else if (r < add_w + rem_w + qry_w)
				op = KIND_QUERY;
			else
				op = KIND_CLEAR;
			if ($urandom_range(99) < 75)
				word = word_pool[$urandom_range(5)];
			else
				word = $urandom;
			send_item(op, word);
		end
	endtask

	// Empty-store cases, duplicates, swap on remove, misses
	task automatic test_directed_basics();
		set_idling(0, 0);
		send_item(KIND_CLEAR,  WORD_ALT);
		send_item(KIND_REMOVE, WORD_ZERO);
		send_item(KIND_QUERY,  WORD_ZERO);
		send_item(KIND_ADD,    WORD_ZERO);
		send_item(KIND_ADD,    WORD_ONES);
		send_item(KIND_ADD,    WORD_ZERO);
		send_item(KIND_QUERY,  WORD_ZERO);
		send_item(KIND_REMOVE, WORD_ZERO);
		send_item(KIND_REMOVE, WORD_ALT);
		send_item(KIND_QUERY,  WORD_ONES);
		send_item(KIND_REMOVE, WORD_ONES);
		send_item(KIND_REMOVE, WORD_ZERO);
	endtask

	// One word fills every slot: count reaches capacity, add when full, clear when full
	task automatic test_full_store();
		set_idling(0, 0);
		for (int i = 0; i < BAG_DEPTH; i++)
			send_item(KIND_ADD, WORD_EDGE);
		send_item(KIND_ADD,   WORD_ALT);
		send_item(KIND_QUERY, WORD_EDGE);
		send_item(KIND_CLEAR, WORD_EDGE);
	endtask

	task automatic test_random_phases();
		refresh_pool();
		set_idling(0, 0);
		random_ops(340, 45, 30, 20);
		refresh_pool();
		set_idling(62, 0);
		random_ops(340, 45, 30, 20);
		refresh_pool();
		set_idling(0, 62);
		random_ops(340, 45, 30, 20);
		refresh_pool();
		set_idling(11, 11);
		random_ops(340, 45, 30, 20);
		// add-heavy to spend time at and around full
		refresh_pool();
		set_idling(0, 0);
		random_ops(340, 60, 20, 17);
	endtask

	// Result side holds off while items keep coming, so the input stalls
	task automatic test_backpressure_hold();
		refresh_pool();
		set_idling(0, 0);
		hold_left = 400;
		random_ops(80, 45, 30, 20);
	endtask

	initial begin
		set_idling(0, 0);
		hold_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_basics();
		test_full_store();
		test_random_phases();
		test_backpressure_hold();

		s_tvalid <= 1'b0;
		while (bag_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d items (add %0d, remove %0d, query %0d, clear %0d), %0d results checked",
			items_sent, kind_seen[KIND_ADD], kind_seen[KIND_REMOVE], kind_seen[KIND_QUERY],
			kind_seen[KIND_CLEAR], results_checked);
		$display("Store full after %0d ops, %0d adds refused, removes %0d hit / %0d missed",
			full_seen, rejected_adds, remove_hits, remove_misses);
		if (bag_results_due.size() != 0)
			report_mismatch("results never delivered", 0, bag_results_due.size());
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
